### hdl/qph_pkg.sv
// Shared constants, codes and types of the quadratic probe hash table.
// No dependencies; imported by qph_mod, qph_probe, the top level and qph_checker.
`timescale 1ns / 1ps

package qph_pkg;

  localparam int SLOTS  = 1024;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int SIZE_W = SLOT_W + 1;
  localparam int KEY_W  = 31;
  localparam int CNT_W  = $clog2(KEY_W);
  localparam int MODE_W = 2;
  localparam int STAT_W = 3;
  localparam int ENTRY_W = KEY_W + 1;  // used flag on top of the key

  localparam int IN_W  = ((MODE_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_W = ((STAT_W + SLOT_W + 7) / 8) * 8;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(7);

  // Operation codes
  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ERASE  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NONE   = 2'd3;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_ERASED    = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

  // Probe generator status toward the control logic
  typedef struct packed {
    logic [SLOT_W-1:0] slot;   // slot of the current probe
    logic              first;  // home slot
    logic              last;   // probe n-1
    logic              more;   // probes left to issue
  } probe_t;

endpackage

### hdl/qph_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module qph_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/qph_mod.sv
// Restoring remainder unit: key mod table size, one key bit per cycle.
// Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_mod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [qph_pkg::KEY_W-1:0]  dividend_i,
  input  logic [qph_pkg::SIZE_W-1:0] divisor_i,
  output logic                      done_o,
  output logic [qph_pkg::SLOT_W-1:0] rem_o
);
  import qph_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [KEY_W-1:0]  dvd_q, dvd_d;
  logic [SIZE_W-1:0] rem_q, rem_d;
  logic [SIZE_W:0]   trial;

  assign trial = {rem_q, dvd_q[KEY_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the divisor, so one subtract per bit
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = SIZE_W'(trial - {1'b0, divisor_i});
      end else begin
        rem_d = trial[SIZE_W-1:0];
      end
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q[SLOT_W-1:0];

endmodule

### hdl/qph_probe.sv
// Quadratic probe sequence: slot (home + k*k) mod n, stepped by adding 2k+1 mod n.
// Depends on qph_pkg.
`timescale 1ns / 1ps

module qph_probe (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [qph_pkg::SLOT_W-1:0] home_i,
  input  logic [qph_pkg::SIZE_W-1:0] n_i,
  input  logic                      step_i,
  output qph_pkg::probe_t            probe_o
);
  import qph_pkg::*;

  logic [SLOT_W-1:0] pos_q, pos_d;
  logic [SLOT_W-1:0] delta_q, delta_d;
  logic [SIZE_W-1:0] k_q, k_d;
  logic [SIZE_W-1:0] pos_sum, delta_sum;
  logic              n_one;

  assign n_one     = (n_i == SIZE_W'(1));
  assign pos_sum   = {1'b0, pos_q} + {1'b0, delta_q};
  assign delta_sum = {1'b0, delta_q} + SIZE_W'(2);

  always_comb begin
    pos_d   = pos_q;
    delta_d = delta_q;
    k_d     = k_q;
    if (start_i) begin
      pos_d   = home_i;
      delta_d = n_one ? '0 : SLOT_W'(1);
      k_d     = '0;
    end else if (step_i) begin
      k_d = k_q + 1'b1;
      if (pos_sum >= n_i) begin
        pos_d = SLOT_W'(pos_sum - n_i);
      end else begin
        pos_d = pos_sum[SLOT_W-1:0];
      end
      if (n_one) begin
        delta_d = '0;
      end else if (delta_sum >= n_i) begin
        delta_d = SLOT_W'(delta_sum - n_i);
      end else begin
        delta_d = delta_sum[SLOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= '0;
    end else begin
      k_q <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q   <= pos_d;
    delta_q <= delta_d;
  end

  assign probe_o.slot  = pos_q;
  assign probe_o.first = (k_q == '0);
  assign probe_o.last  = (k_q == SIZE_W'(n_i - 1'b1));
  assign probe_o.more  = (k_q < n_i);

endmodule

### hdl/quadratic_probe_hash_table_top.sv
// Top level of the quadratic probe hash table: control, slot memory, output register.
// Depends on qph_pkg, qph_ram, qph_mod and qph_probe.
//
//   Channel  | Direction | Word
//   ---------+-----------+----------------------------------------------
//   s_axis   | in        | tdata[1:0] mode, tdata[32:2] key
//   m_axis   | out       | tdata[2:0] status, tdata[12:3] slot_index
//   cfg      | in        | cfg_wdata_i = table_size, written when cfg_we_i
//
// After reset a clearing pass writes all 1024 slots with s_axis_tready low.
// One word is then accepted, runs through the bit-serial key mod n unit and
// its done flag, then through probing (one slot memory read per probe,
// pipelined one per cycle), and then its result is loaded. Mode 3 skips
// straight to the result. A new word is taken while the previous result
// still sits in the output register; a stalled m_axis holds the block in
// its result state.
`timescale 1ns / 1ps

module quadratic_probe_hash_table_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // config: table_size
  input  logic                      cfg_we_i,
  input  logic [qph_pkg::SIZE_W-1:0] cfg_wdata_i,
  // input stream
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [qph_pkg::IN_W-1:0]   s_axis_tdata,   // mode[1:0], key[32:2], zero fill
  // result stream
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [qph_pkg::OUT_W-1:0]  m_axis_tdata    // status[2:0], slot_index[12:3], zero fill
);
  import qph_pkg::*;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_PROBE = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SIZE_W-1:0] size_q;
  logic [SIZE_W-1:0] n_act;
  logic [SLOT_W-1:0] clr_q, clr_d;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [KEY_W-1:0]  key_q, key_d;

  logic [STAT_W-1:0] res_stat_q, res_stat_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;

  logic              out_valid_q, out_valid_d;
  logic [STAT_W-1:0] out_stat_q, out_stat_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;

  // probe read pipeline: one read in flight per cycle
  logic              rd_v_q;
  logic [SLOT_W-1:0] rd_slot_q;
  logic              rd_first_q, rd_last_q;

  logic              accept;
  logic              div_start, div_done;
  logic [SLOT_W-1:0] home;
  probe_t            probe;
  logic              issue;
  logic              finish;

  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENTRY_W-1:0] mem_wdata;
  logic [ENTRY_W-1:0] mem_rdata;
  logic               ent_used;
  logic [KEY_W-1:0]   ent_key;

  // Size 0 behaves as 1, above SLOTS as SLOTS
  always_comb begin
    if (size_q == '0) begin
      n_act = SIZE_W'(1);
    end else if (size_q > SIZE_W'(SLOTS)) begin
      n_act = SIZE_W'(SLOTS);
    end else begin
      n_act = size_q;
    end
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign div_start     = accept && (s_axis_tdata[MODE_W-1:0] != MODE_NONE);

  assign ent_used = mem_rdata[ENTRY_W-1];
  assign ent_key  = mem_rdata[KEY_W-1:0];

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    mode_d      = mode_q;
    key_d       = key_q;
    res_stat_d  = res_stat_q;
    res_slot_d  = res_slot_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_stat_d  = out_stat_q;
    out_slot_d  = out_slot_q;
    finish      = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = rd_slot_q;
    mem_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          mode_d = s_axis_tdata[MODE_W-1:0];
          key_d  = s_axis_tdata[MODE_W +: KEY_W];
          if (s_axis_tdata[MODE_W-1:0] == MODE_NONE) begin
            res_stat_d = ST_NOT_FOUND;
            res_slot_d = '0;
            state_d    = S_DONE;
          end else begin
            state_d = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (rd_v_q) begin
          if (mode_q == MODE_INSERT) begin
            if (!ent_used) begin
              finish     = 1'b1;
              mem_we     = 1'b1;
              mem_wdata  = {1'b1, key_q};
              res_stat_d = ST_INSERTED;
              res_slot_d = rd_slot_q;
            end else if (rd_last_q) begin
              finish     = 1'b1;
              res_stat_d = ST_FULL;
              res_slot_d = '0;
            end
          end else begin
            if (rd_first_q && !ent_used) begin
              // empty home slot: miss without scanning
              finish     = 1'b1;
              res_stat_d = ST_NOT_FOUND;
              res_slot_d = '0;
            end else if (ent_used && (ent_key == key_q)) begin
              finish     = 1'b1;
              res_slot_d = rd_slot_q;
              if (mode_q == MODE_ERASE) begin
                mem_we     = 1'b1;
                res_stat_d = ST_ERASED;
              end else begin
                res_stat_d = ST_FOUND;
              end
            end else if (rd_last_q) begin
              finish     = 1'b1;
              res_stat_d = ST_NOT_FOUND;
              res_slot_d = '0;
            end
          end
        end
        if (finish) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_slot_d  = res_slot_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A read issued in the finishing cycle is dropped, so a write never races it
  assign issue = (state_q == S_PROBE) && probe.more && !finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      size_q      <= SIZE_RESET;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= issue;
      if (cfg_we_i) begin
        size_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    key_q      <= key_d;
    res_stat_q <= res_stat_d;
    res_slot_q <= res_slot_d;
    out_stat_q <= out_stat_d;
    out_slot_q <= out_slot_d;
    if (issue) begin
      rd_slot_q  <= probe.slot;
      rd_first_q <= probe.first;
      rd_last_q  <= probe.last;
    end
  end

  qph_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_axis_tdata[MODE_W +: KEY_W]),
    .divisor_i  (n_act),
    .done_o     (div_done),
    .rem_o      (home)
  );

  qph_probe u_probe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_done),
    .home_i  (home),
    .n_i     (n_act),
    .step_i  (issue),
    .probe_o (probe)
  );

  // Slot store: used flag in the top bit, key below
  qph_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (issue),
    .raddr_i (probe.slot),
    .rdata_o (mem_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_W - STAT_W - SLOT_W)'(0), out_slot_q, out_stat_q};

endmodule

### hdl/qph_checker.sv
// Port-level checks on the hash table top, bound to every instance.
// Depends on qph_pkg and quadratic_probe_hash_table_top.
`timescale 1ns / 1ps

module qph_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [qph_pkg::OUT_W-1:0]  m_axis_tdata
);
  import qph_pkg::*;

  logic [STAT_W-1:0] st;
  logic [SLOT_W-1:0] slot;

  assign st   = m_axis_tdata[STAT_W-1:0];
  assign slot = m_axis_tdata[STAT_W +: SLOT_W];

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (st == ST_INSERTED || st == ST_FOUND || st == ST_NOT_FOUND ||
                       st == ST_ERASED || st == ST_FULL))
    else $error("undefined status code");

  // Misses and full report slot zero
  a_miss_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (st == ST_NOT_FOUND || st == ST_FULL)) |-> (slot == '0))
    else $error("miss or full with nonzero slot");

  // One word at a time: busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken on back-to-back cycles");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind quadratic_probe_hash_table_top qph_checker u_qph_checker (.*);
